[rtl/core/adam_pkg.sv]
`default_nettype none
package adam_pkg;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         param_index;
		logic signed [31:0] value;
		logic               first_of_step;
	} adam_req_t;

	typedef struct packed {
		logic [5:0]         out_index;
		logic signed [31:0] new_theta;
	} adam_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_PW1,
		ST_PW2,
		ST_MA,
		ST_MB,
		ST_GSQ,
		ST_VA,
		ST_VB,
		ST_DIVM,
		ST_DIVV,
		ST_SQRT,
		ST_MULS,
		ST_DIVS
	} adam_state_t;

	localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] CFG_FIRST_DECAY   = 2'd1;
	localparam logic [1:0] CFG_SECOND_DECAY  = 2'd2;
	localparam logic [1:0] CFG_STABILIZER    = 2'd3;

	localparam logic       CMD_LOAD   = 1'b0;
	localparam logic       CMD_UPDATE = 1'b1;

	localparam logic [15:0] LEARNING_RATE_RST = 16'd655;
	localparam logic [15:0] FIRST_DECAY_RST   = 16'd58982;
	localparam logic [15:0] SECOND_DECAY_RST  = 16'd64881;
	localparam logic [15:0] STABILIZER_RST    = 16'd1;
	localparam logic [15:0] POWER_ONE_CODE    = 16'hFFFF;
	localparam logic [16:0] ONE_Q16           = 17'h10000;
	localparam logic [33:0] STEP_MAX          = 34'h200000000;

endpackage
`default_nettype wire

[rtl/core/adam_optimizer_update.sv]
`default_nettype none
// Adam update engine, one parameter element per transaction, fixed point.
// Command channel: req is taken at a clock edge with start high and busy low.
// A load (cmd 0) writes theta and clears both moments; an update (cmd 1)
// applies one gradient and, with first_of_step set, advances the decay powers.
// An index at or above NUM_PARAMS is dropped with no result.
// Result channel: done is high for one cycle with rsp holding the element
// index and its new theta; the receiver cannot stall it.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data,
// always ready; write only while busy is low and no result is pending.
// A load returns its result in the cycle after acceptance and busy stays low.
// An update holds busy high while it runs the shared shift-add multiplier
// (one multiplier bit per cycle), the restoring divider (one quotient bit per
// cycle, 64 per division) and the square-root unit (one root bit per cycle),
// with the two decay-power products first when the powers advance.
// Reset returns the configuration registers to their defaults and both decay powers to one.
// Element stores are undefined until loaded.
module adam_optimizer_update #(
	parameter int NUM_PARAMS = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire adam_pkg::adam_req_t req,
	output logic                     done,
	output adam_pkg::adam_rsp_t      rsp,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire [1:0]                cfg_index,
	input  wire [15:0]               cfg_data
);

	localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	localparam logic [12:0] NUM_LIMIT = 13'(NUM_PARAMS);

	adam_pkg::adam_state_t state_q, state_d;

	logic [15:0] alpha_q, beta1_q, beta2_q, eps_q;
	logic [15:0] p1_q, p2_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	adam_pkg::adam_rsp_t rsp_q;

	logic signed [31:0] theta_mem [NUM_PARAMS];
	logic signed [31:0] m_mem     [NUM_PARAMS];
	logic [47:0]        v_mem     [NUM_PARAMS];
	logic signed [31:0] rd_theta_q, rd_m_q;
	logic [47:0]        rd_v_q;

	logic [5:0]         idx_q;
	logic signed [31:0] g_q, theta_q, m_q;
	logic               first_q, neg_q;
	logic [31:0]        mmag_q;
	logic [46:0]        g2_q;
	logic [47:0]        v_q;

	logic signed [67:0] acc_q, mc_q, acc_nx;
	logic [31:0]        mr_q;
	logic [63:0]        dvd_q, dvd_nx;
	logic [32:0]        dvs_q;
	logic [35:0]        rem_q, rem_nx;
	logic [31:0]        root_q;

	logic        last, accept, in_range, load_go, wr_upd;
	logic [12:0] idx_ext_in, idx_ext_q;
	logic [AW-1:0] addr_in, addr_q;
	logic [16:0] pv1, pv2, d1, d2, omb1, omb2;
	logic [15:0] pclamp;
	logic [31:0] gmag, mnew, mnew_mag;
	logic [47:0] vsat, vhat;
	logic [35:0] rem_sh, srem_sh, trial;
	logic        ge, sge;
	logic [31:0] root_nx;
	logic [32:0] den_raw, den;
	logic [33:0] step;
	logic signed [34:0] res_wide;
	logic signed [31:0] res32;

	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign rsp        = rsp_q;
	assign last       = (cnt_q == 6'd0);
	assign idx_ext_in = {7'd0, req.param_index};
	assign idx_ext_q  = {7'd0, idx_q};
	assign addr_in    = idx_ext_in[AW-1:0];
	assign addr_q     = idx_ext_q[AW-1:0];
	assign in_range   = idx_ext_in < NUM_LIMIT;
	assign accept     = start && !busy;
	assign load_go    = accept && in_range && (req.cmd == adam_pkg::CMD_LOAD);

	assign pv1  = (p1_q == adam_pkg::POWER_ONE_CODE) ? adam_pkg::ONE_Q16 : {1'b0, p1_q};
	assign pv2  = (p2_q == adam_pkg::POWER_ONE_CODE) ? adam_pkg::ONE_Q16 : {1'b0, p2_q};
	assign d1   = (adam_pkg::ONE_Q16 == pv1) ? adam_pkg::ONE_Q16 : adam_pkg::ONE_Q16 - pv1;
	assign d2   = (adam_pkg::ONE_Q16 == pv2) ? adam_pkg::ONE_Q16 : adam_pkg::ONE_Q16 - pv2;
	assign omb1 = adam_pkg::ONE_Q16 - {1'b0, beta1_q};
	assign omb2 = adam_pkg::ONE_Q16 - {1'b0, beta2_q};
	assign gmag = g_q[31] ? (~g_q + 32'd1) : g_q;

	assign acc_nx   = acc_q + (mr_q[0] ? mc_q : 68'sd0);
	assign pclamp   = (acc_nx[67:32] != 36'd0) ? 16'hFFFF : acc_nx[31:16];
	assign mnew     = acc_nx[47:16];
	assign mnew_mag = mnew[31] ? (~mnew + 32'd1) : mnew;
	assign vsat     = (acc_nx[67:64] != 4'd0) ? 48'hFFFFFFFFFFFF : acc_nx[63:16];

	assign rem_sh = {rem_q[34:0], dvd_q[63]};
	assign ge     = rem_sh >= {3'd0, dvs_q};
	assign rem_nx = ge ? rem_sh - {3'd0, dvs_q} : rem_sh;
	assign dvd_nx = {dvd_q[62:0], ge};
	assign vhat   = (dvd_nx[63:48] != 16'd0) ? 48'hFFFFFFFFFFFF : dvd_nx[47:0];

	assign srem_sh = {rem_q[33:0], dvd_q[63:62]};
	assign trial   = {2'd0, root_q, 2'b01};
	assign sge     = srem_sh >= trial;
	assign root_nx = {root_q[30:0], sge};
	assign den_raw = {1'b0, root_nx} + {17'd0, eps_q};
	assign den     = (den_raw == 33'd0) ? 33'd1 : den_raw;

	assign step = ((dvd_nx[63:34] != 30'd0) || (dvd_nx[33:0] > adam_pkg::STEP_MAX)) ?
		adam_pkg::STEP_MAX : dvd_nx[33:0];
	assign res_wide = neg_q ? {{3{theta_q[31]}}, theta_q} + $signed({1'b0, step}) :
		{{3{theta_q[31]}}, theta_q} - $signed({1'b0, step});
	assign res32 = (res_wide > 35'sd2147483647) ? 32'sh7FFFFFFF :
		(res_wide < -35'sd2147483648) ? 32'sh80000000 : res_wide[31:0];

	function automatic logic [5:0] steps_of(adam_pkg::adam_state_t s);
		case (s)
			adam_pkg::ST_PW1, adam_pkg::ST_PW2, adam_pkg::ST_MA,
			adam_pkg::ST_VA, adam_pkg::ST_MULS: steps_of = 6'd15;
			adam_pkg::ST_MB, adam_pkg::ST_VB: steps_of = 6'd16;
			adam_pkg::ST_GSQ, adam_pkg::ST_SQRT: steps_of = 6'd31;
			adam_pkg::ST_DIVM, adam_pkg::ST_DIVV, adam_pkg::ST_DIVS: steps_of = 6'd63;
			default: steps_of = 6'd0;
		endcase
	endfunction

	always_comb begin
		state_d = state_q;
		case (state_q)
			adam_pkg::ST_IDLE: begin
				if (accept && in_range && (req.cmd == adam_pkg::CMD_UPDATE)) begin
					state_d = adam_pkg::ST_RD;
				end
			end
			adam_pkg::ST_RD: state_d = first_q ? adam_pkg::ST_PW1 : adam_pkg::ST_MA;
			adam_pkg::ST_PW1: if (last) state_d = adam_pkg::ST_PW2;
			adam_pkg::ST_PW2: if (last) state_d = adam_pkg::ST_MA;
			adam_pkg::ST_MA: if (last) state_d = adam_pkg::ST_MB;
			adam_pkg::ST_MB: if (last) state_d = adam_pkg::ST_GSQ;
			adam_pkg::ST_GSQ: if (last) state_d = adam_pkg::ST_VA;
			adam_pkg::ST_VA: if (last) state_d = adam_pkg::ST_VB;
			adam_pkg::ST_VB: if (last) state_d = adam_pkg::ST_DIVM;
			adam_pkg::ST_DIVM: if (last) state_d = adam_pkg::ST_DIVV;
			adam_pkg::ST_DIVV: if (last) state_d = adam_pkg::ST_SQRT;
			adam_pkg::ST_SQRT: if (last) state_d = adam_pkg::ST_MULS;
			adam_pkg::ST_MULS: if (last) state_d = adam_pkg::ST_DIVS;
			adam_pkg::ST_DIVS: if (last) state_d = adam_pkg::ST_IDLE;
			default: state_d = adam_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != adam_pkg::ST_IDLE);
		wr_upd = (state_q == adam_pkg::ST_DIVS) && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adam_pkg::ST_IDLE;
			cnt_q   <= 6'd0;
			done_q  <= 1'b0;
			p1_q    <= adam_pkg::POWER_ONE_CODE;
			p2_q    <= adam_pkg::POWER_ONE_CODE;
			alpha_q <= adam_pkg::LEARNING_RATE_RST;
			beta1_q <= adam_pkg::FIRST_DECAY_RST;
			beta2_q <= adam_pkg::SECOND_DECAY_RST;
			eps_q   <= adam_pkg::STABILIZER_RST;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= steps_of(state_d);
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
			end
			done_q <= load_go || wr_upd;
			if ((state_q == adam_pkg::ST_PW1) && last) p1_q <= pclamp;
			if ((state_q == adam_pkg::ST_PW2) && last) p2_q <= pclamp;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					adam_pkg::CFG_LEARNING_RATE: alpha_q <= cfg_data;
					adam_pkg::CFG_FIRST_DECAY:   beta1_q <= cfg_data;
					adam_pkg::CFG_SECOND_DECAY:  beta2_q <= cfg_data;
					adam_pkg::CFG_STABILIZER:    eps_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == adam_pkg::ST_IDLE) begin
			rd_theta_q <= theta_mem[addr_in];
			rd_m_q     <= m_mem[addr_in];
			rd_v_q     <= v_mem[addr_in];
		end
		if (load_go) begin
			theta_mem[addr_in] <= req.value;
			m_mem[addr_in]     <= 32'sd0;
			v_mem[addr_in]     <= 48'd0;
		end else if (wr_upd) begin
			theta_mem[addr_q] <= res32;
			m_mem[addr_q]     <= m_q;
			v_mem[addr_q]     <= v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_go) begin
			rsp_q.out_index <= req.param_index;
			rsp_q.new_theta <= req.value;
		end else if (wr_upd) begin
			rsp_q.out_index <= idx_q;
			rsp_q.new_theta <= res32;
		end
		case (state_q)
			adam_pkg::ST_IDLE: begin
				idx_q   <= req.param_index;
				g_q     <= req.value;
				first_q <= req.first_of_step;
			end
			adam_pkg::ST_RD: begin
				theta_q <= rd_theta_q;
				if (first_q) begin
					acc_q <= 68'sd32768;
					mc_q  <= {51'd0, pv1};
					mr_q  <= {16'd0, beta1_q};
				end else begin
					acc_q <= 68'sd32768;
					mc_q  <= {{36{rd_m_q[31]}}, rd_m_q};
					mr_q  <= {16'd0, beta1_q};
				end
			end
			adam_pkg::ST_PW1, adam_pkg::ST_PW2, adam_pkg::ST_MA, adam_pkg::ST_MB,
			adam_pkg::ST_GSQ, adam_pkg::ST_VA, adam_pkg::ST_VB, adam_pkg::ST_MULS: begin
				acc_q <= acc_nx;
				mc_q  <= mc_q <<< 1;
				mr_q  <= mr_q >> 1;
				if (last) begin
					case (state_q)
						adam_pkg::ST_PW1: begin
							acc_q <= 68'sd32768;
							mc_q  <= {51'd0, pv2};
							mr_q  <= {16'd0, beta2_q};
						end
						adam_pkg::ST_PW2: begin
							acc_q <= 68'sd32768;
							mc_q  <= {{36{rd_m_q[31]}}, rd_m_q};
							mr_q  <= {16'd0, beta1_q};
						end
						adam_pkg::ST_MA: begin
							mc_q <= {{36{g_q[31]}}, g_q};
							mr_q <= {15'd0, omb1};
						end
						adam_pkg::ST_MB: begin
							m_q    <= mnew;
							neg_q  <= mnew[31];
							mmag_q <= mnew_mag;
							acc_q  <= 68'sd0;
							mc_q   <= {36'd0, gmag};
							mr_q   <= gmag;
						end
						adam_pkg::ST_GSQ: begin
							g2_q  <= acc_nx[62:16];
							acc_q <= 68'sd32768;
							mc_q  <= {20'd0, rd_v_q};
							mr_q  <= {16'd0, beta2_q};
						end
						adam_pkg::ST_VA: begin
							mc_q <= {21'd0, g2_q};
							mr_q <= {15'd0, omb2};
						end
						adam_pkg::ST_VB: begin
							v_q   <= vsat;
							dvd_q <= {16'd0, mmag_q, 16'd0};
							dvs_q <= {16'd0, d1};
							rem_q <= 36'd0;
						end
						adam_pkg::ST_MULS: begin
							dvd_q <= acc_nx[63:0];
							rem_q <= 36'd0;
						end
						default: ;
					endcase
				end
			end
			adam_pkg::ST_DIVM, adam_pkg::ST_DIVV, adam_pkg::ST_DIVS: begin
				rem_q <= rem_nx;
				dvd_q <= dvd_nx;
				if (last) begin
					case (state_q)
						adam_pkg::ST_DIVM: begin
							acc_q <= {21'd0, dvd_nx[46:0]};
							dvd_q <= {v_q, 16'd0};
							dvs_q <= {16'd0, d2};
							rem_q <= 36'd0;
						end
						adam_pkg::ST_DIVV: begin
							dvd_q  <= {vhat, 16'd0};
							rem_q  <= 36'd0;
							root_q <= 32'd0;
						end
						default: ;
					endcase
				end
			end
			adam_pkg::ST_SQRT: begin
				rem_q  <= sge ? srem_sh - trial : srem_sh;
				root_q <= root_nx;
				dvd_q  <= {dvd_q[61:0], 2'b00};
				if (last) begin
					dvs_q <= den;
					mc_q  <= acc_q;
					acc_q <= 68'sd0;
					mr_q  <= {16'd0, alpha_q};
				end
			end
			default: ;
		endcase
	end

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == adam_pkg::ST_DIVS || $past(state_q) == adam_pkg::ST_IDLE))
		else $error("result strobe without a finished transaction");

	a_power_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(p1_q) |-> $past(state_q) == adam_pkg::ST_PW1)
		else $error("first decay power changed outside its advance");

	a_update_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_range && req.cmd == adam_pkg::CMD_UPDATE) |=> state_q == adam_pkg::ST_RD)
		else $error("accepted update did not start");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adam_pkg::ST_DIVS || state_q == adam_pkg::ST_DIVM) |-> dvs_q != 33'd0)
		else $error("zero divisor in divider");

endmodule
`default_nettype wire

[verif/adam_update_checker.sv]
`timescale 1ns / 100ps
module adam_update_checker (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire                 busy,
	input  adam_pkg::adam_req_t req,
	input  wire                 done,
	input  adam_pkg::adam_rsp_t rsp,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire [1:0]           cfg_index,
	input  wire [15:0]          cfg_data,
	output int                  errors,
	output int                  outstanding
);

	localparam logic [63:0] MOMENT_SAT = 64'hFFFF_FFFF_FFFF;

	logic [15:0]         alpha, beta1, beta2, eps;
	logic [15:0]         pow1, pow2;
	logic signed [31:0]  theta_mem [64];
	logic signed [31:0]  m_mem [64];
	logic [47:0]         v_mem [64];
	adam_pkg::adam_rsp_t theta_q [$];

	function automatic logic [16:0] power_of(logic [15:0] code);
		return (code == adam_pkg::POWER_ONE_CODE) ? adam_pkg::ONE_Q16 : {1'b0, code};
	endfunction

	function automatic logic [15:0] power_advance(logic [15:0] code, logic [15:0] beta);
		logic [63:0] p;
		p = (64'(power_of(code)) * 64'(beta) + 64'd32768) >> 16;
		return (p > 64'd65535) ? 16'hFFFF : p[15:0];
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic adam_pkg::adam_rsp_t theta_update(adam_pkg::adam_req_t r);
		adam_pkg::adam_rsp_t o;
		int                  i;
		longint              g, b1s, mw, th, res;
		logic [63:0]         absg, g2, vs, d1, d2, mag, mhat, vhat, root, den, step;
		logic [127:0]        vsum;
		logic                neg;
		i = r.param_index;
		g = r.value;
		o.out_index = r.param_index;
		if (r.cmd == adam_pkg::CMD_LOAD) begin
			theta_mem[i] = r.value;
			m_mem[i] = 0;
			v_mem[i] = 0;
			o.new_theta = r.value;
			return o;
		end
		if (r.first_of_step) begin
			pow1 = power_advance(pow1, beta1);
			pow2 = power_advance(pow2, beta2);
		end
		b1s = beta1;
		mw = (b1s * longint'(m_mem[i]) + (65536 - b1s) * g + 32768) >>> 16;
		m_mem[i] = mw[31:0];
		absg = (g < 0) ? -g : g;
		g2 = (absg * absg) >> 16;
		vsum = 128'(beta2) * 128'(v_mem[i]) + 128'(32'd65536 - beta2) * 128'(g2) + 128'd32768;
		vs = ((vsum >> 16) > 128'(MOMENT_SAT)) ? MOMENT_SAT : 64'(vsum >> 16);
		v_mem[i] = vs[47:0];
		d1 = 64'd65536 - 64'(power_of(pow1));
		d2 = 64'd65536 - 64'(power_of(pow2));
		if (d1 == 0) d1 = 64'd65536;
		if (d2 == 0) d2 = 64'd65536;
		neg = mw < 0;
		mag = neg ? -mw : mw;
		mhat = (mag << 16) / d1;
		vhat = (vs << 16) / d2;
		if (vhat > MOMENT_SAT) vhat = MOMENT_SAT;
		root = int_sqrt(vhat << 16);
		den = root + 64'(eps);
		if (den == 0) den = 1;
		step = (64'(alpha) * mhat) / den;
		if (step > 64'(adam_pkg::STEP_MAX)) step = 64'(adam_pkg::STEP_MAX);
		th = theta_mem[i];
		res = neg ? th + longint'(step) : th - longint'(step);
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		theta_mem[i] = res[31:0];
		o.new_theta = res[31:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		adam_pkg::adam_rsp_t exp_rsp;
		if (!arst_n) begin
			alpha = adam_pkg::LEARNING_RATE_RST;
			beta1 = adam_pkg::FIRST_DECAY_RST;
			beta2 = adam_pkg::SECOND_DECAY_RST;
			eps = adam_pkg::STABILIZER_RST;
			pow1 = adam_pkg::POWER_ONE_CODE;
			pow2 = adam_pkg::POWER_ONE_CODE;
			errors = 0;
			theta_q.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (theta_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: index %0d theta %0d", rsp.out_index,
							rsp.new_theta);
				end else begin
					exp_rsp = theta_q.pop_front();
					if (rsp.out_index !== exp_rsp.out_index || rsp.new_theta !== exp_rsp.new_theta) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected index %0d theta %0d, got index %0d theta %0d",
								exp_rsp.out_index, exp_rsp.new_theta, rsp.out_index, rsp.new_theta);
					end
				end
			end
			if (start && !busy)
				theta_q.insert(theta_q.size(), theta_update(req));
			outstanding = theta_q.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					adam_pkg::CFG_LEARNING_RATE: alpha = cfg_data;
					adam_pkg::CFG_FIRST_DECAY:   beta1 = cfg_data;
					adam_pkg::CFG_SECOND_DECAY:  beta2 = cfg_data;
					adam_pkg::CFG_STABILIZER:    eps = cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule

[verif/adam_optimizer_update_tb.sv]
`timescale 1ns / 100ps
module adam_optimizer_update_tb;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                start = 0;
	adam_pkg::adam_req_t req = '0;
	logic                cfg_valid = 0;
	logic [1:0]          cfg_index = adam_pkg::CFG_LEARNING_RATE;
	logic [15:0]         cfg_data = 0;
	logic                busy, done, cfg_ready;
	adam_pkg::adam_rsp_t rsp;
	int                  errors, outstanding;
	logic                loaded [64];
	bit                  gaps = 1;

	always #1 clk = ~clk;

	adam_optimizer_update dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req), .done(done),
		.rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	adam_update_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req), .done(done),
		.rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .outstanding(outstanding)
	);

	task automatic send(logic cmd, logic [5:0] idx, logic [31:0] val, logic fos);
		start <= 1;
		req <= '{cmd: cmd, param_index: idx, value: val, first_of_step: fos};
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		if (cmd == adam_pkg::CMD_LOAD) loaded[idx] = 1;
		if (gaps && $urandom_range(3) == 0) begin
			start <= 0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] a, logic [15:0] b1, logic [15:0] b2, logic [15:0] e);
		drain();
		write_reg(adam_pkg::CFG_LEARNING_RATE, a);
		write_reg(adam_pkg::CFG_FIRST_DECAY, b1);
		write_reg(adam_pkg::CFG_SECOND_DECAY, b2);
		write_reg(adam_pkg::CFG_STABILIZER, e);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(131072) - 65536;
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	task automatic random_phase(int n);
		int k;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(63);
			if (!loaded[k] || $urandom_range(9) == 0)
				send(adam_pkg::CMD_LOAD, 6'(k), rand_value(), 1'($urandom));
			else
				send(adam_pkg::CMD_UPDATE, 6'(k), rand_value(), $urandom_range(7) == 0);
		end
	endtask

	initial begin
		foreach (loaded[i]) loaded[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(adam_pkg::CMD_LOAD, 6'd0, 32'h7FFF_FFFF, 1'b1);
		send(adam_pkg::CMD_LOAD, 6'd63, 32'h8000_0000, 1'b0);
		send(adam_pkg::CMD_LOAD, 6'd1, 32'h0000_0000, 1'b0);
		send(adam_pkg::CMD_LOAD, 6'd2, 32'hFFFF_FFFF, 1'b1);
		send(adam_pkg::CMD_UPDATE, 6'd1, 32'h0001_0000, 1'b0);
		send(adam_pkg::CMD_UPDATE, 6'd0, 32'h8000_0000, 1'b0);
		send(adam_pkg::CMD_UPDATE, 6'd63, 32'h7FFF_FFFF, 1'b1);
		send(adam_pkg::CMD_UPDATE, 6'd2, 32'hFFFF_0000, 1'b0);
		send(adam_pkg::CMD_UPDATE, 6'd1, 32'h8000_0000, 1'b1);
		send(adam_pkg::CMD_UPDATE, 6'd63, 32'h0000_0001, 1'b0);
		set_regs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
		send(adam_pkg::CMD_LOAD, 6'd3, 32'h0000_0000, 1'b0);
		send(adam_pkg::CMD_UPDATE, 6'd3, 32'h0000_0000, 1'b1);
		send(adam_pkg::CMD_UPDATE, 6'd0, 32'h7FFF_FFFF, 1'b1);
		send(adam_pkg::CMD_UPDATE, 6'd63, 32'h8000_0000, 1'b0);
		set_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(adam_pkg::CMD_UPDATE, 6'd0, 32'h1234_5678, 1'b1);
		send(adam_pkg::CMD_UPDATE, 6'd2, 32'h8000_0000, 1'b1);
		set_regs(adam_pkg::LEARNING_RATE_RST, adam_pkg::FIRST_DECAY_RST,
			adam_pkg::SECOND_DECAY_RST, adam_pkg::STABILIZER_RST);
		for (int k = 0; k < 64; k++)
			send(adam_pkg::CMD_LOAD, 6'(k), rand_value(), 1'b0);
		random_phase(100);
		set_regs(16'hFFFF, 16'd32768, 16'd65000, 16'h0000);
		random_phase(100);
		set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		random_phase(70);
		set_regs(16'd1000, 16'hFFFF, 16'h0000, 16'hFFFF);
		gaps = 0;
		random_phase(70);
		start <= 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end
endmodule

[files.f]
rtl/core/adam_pkg.sv
rtl/core/adam_optimizer_update.sv
verif/adam_update_checker.sv
verif/adam_optimizer_update_tb.sv
